// ===== src/magnetic_field_sum_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the magnetic field sum unit
// Shared property wrappers; clock and reset are the module's clk and rst.
// ----------------------------------------------------------------------------
`ifndef MAGNETIC_FIELD_SUM_UNIT_ASSERT_SVH
`define MAGNETIC_FIELD_SUM_UNIT_ASSERT_SVH

// same-cycle implication
`define MFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfs check failed");

// next-cycle implication
`define MFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfs check failed");

`endif

// ===== src/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Types, codes and helpers of the magnetic field sum unit.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int MAX_POLES_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_ACTIVE_POINTS = 2'd0,
    CFG_PERMUTE_MODE  = 2'd1,
    CFG_MIN_DIST_SQ   = 2'd2,
    CFG_HALTED        = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PERM_NONE  = 2'd0,
    PERM_RIGHT = 2'd1,
    PERM_LEFT  = 2'd2,
    PERM_SIX   = 2'd3
  } perm_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_ACC,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] str_x;
    logic signed [31:0] str_y;
    logic signed [31:0] str_z;
  } pole_t;

  // clamp a 33-bit signed value into 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  // row of the six-way order table picked by mode and contribution count
  function automatic logic [2:0] perm_row(input logic [1:0] mode, input logic [2:0] cnt6);
    logic [2:0] c3;
    logic [2:0] r;
    c3 = (cnt6 >= 3'd3) ? cnt6 - 3'd3 : cnt6;
    unique case (mode)
      PERM_RIGHT: r = (c3 == 3'd1) ? 3'd2 : (c3 == 3'd2) ? 3'd1 : 3'd0;
      PERM_LEFT:  r = c3;
      PERM_SIX:   r = cnt6;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  // source component for output component c under table row
  function automatic logic [1:0] perm_src(input logic [2:0] row, input logic [1:0] c);
    logic [5:0] ent;
    unique case (row)
      3'd1:    ent = {2'd1, 2'd2, 2'd0};
      3'd2:    ent = {2'd2, 2'd0, 2'd1};
      3'd3:    ent = {2'd0, 2'd2, 2'd1};
      3'd4:    ent = {2'd2, 2'd1, 2'd0};
      3'd5:    ent = {2'd1, 2'd0, 2'd2};
      default: ent = {2'd0, 2'd1, 2'd2};
    endcase
    unique case (c)
      2'd0:    return ent[5:4];
      2'd1:    return ent[3:2];
      default: return ent[1:0];
    endcase
  endfunction

endpackage

// ===== src/magnetic_field_sum_unit.sv =====
// ----------------------------------------------------------------------------
// magnetic_field_sum_unit
// Sums the saturated Q16.16 field of a table of magnetic poles at a query
// position. A write request loads one pole (position and strength) into the
// pole memory and gives no result. A query request walks poles 0 to
// active_points-1 (capped at MAX_POLES, none while halted) one at a time:
// a memory read, the shared 32x32 multiplier (three squares, three
// strength products), a distance check, then three parallel bit-serial
// dividers and one accumulate step; a pole whose squared distance is at
// most min_distance_sq is skipped. No new request is taken until a query
// is done. A new request is taken while a result still waits at the
// output.
// ----------------------------------------------------------------------------
`include "magnetic_field_sum_unit_assert.svh"

module magnetic_field_sum_unit #(
  parameter int MAX_POLES = mfs_pkg::MAX_POLES_DEF,
  parameter int FRAC_BITS = mfs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [0:0]         op,
  input  logic [3:0]         entry_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] strength_x,
  input  logic signed [31:0] strength_y,
  input  logic signed [31:0] strength_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] field_x,
  output logic signed [31:0] field_y,
  output logic signed [31:0] field_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int IDX_W = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
  localparam int CW    = $clog2(MAX_POLES + 1);
  localparam int DW    = 63 + FRAC_BITS;
  localparam int DCW   = $clog2(DW);

  // configuration
  logic [4:0]  active_points;
  logic [1:0]  permute_mode;
  logic [15:0] min_distance_sq;
  logic        halted;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_points   <= 5'd0;
      permute_mode    <= 2'd0;
      min_distance_sq <= 16'd1;
      halted          <= 1'b0;
    end else if (cfg_valid) begin
      unique case (mfs_pkg::cfg_reg_t'(cfg_index))
        mfs_pkg::CFG_ACTIVE_POINTS: active_points   <= cfg_data[4:0];
        mfs_pkg::CFG_PERMUTE_MODE:  permute_mode    <= cfg_data[1:0];
        mfs_pkg::CFG_MIN_DIST_SQ:   min_distance_sq <= cfg_data;
        mfs_pkg::CFG_HALTED:        halted          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pole memory
  mfs_pkg::pole_t pole_mem [MAX_POLES];
  mfs_pkg::pole_t rd_data;

  mfs_pkg::state_t state, state_next;
  logic [CW-1:0]   pole_idx;
  logic [CW-1:0]   pole_cnt;

  logic in_acc;
  logic is_query;
  logic wr_ok;
  logic [CW-1:0] start_cnt;

  assign in_ready = (state == mfs_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign is_query = (mfs_pkg::op_t'(op) == mfs_pkg::OP_QUERY);
  assign wr_ok    = ({28'd0, entry_index} < MAX_POLES);

  always_comb begin
    if (halted) begin
      start_cnt = '0;
    end else if (int'(active_points) > MAX_POLES) begin
      start_cnt = CW'(MAX_POLES);
    end else begin
      start_cnt = CW'(active_points);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_query && wr_ok) begin
      pole_mem[IDX_W'(entry_index)] <= '{pos_x, pos_y, pos_z,
                                         strength_x, strength_y, strength_z};
    end
    if (state == mfs_pkg::ST_READ) begin
      rd_data <= pole_mem[pole_idx[IDX_W-1:0]];
    end
  end

  // datapath registers
  logic signed [31:0] qv [3];
  logic signed [31:0] vo [3];
  logic signed [31:0] kk [3];
  logic signed [31:0] acc [3];
  logic [63:0]        dsq;
  logic [2:0]         mul_step;
  logic signed [63:0] prod;
  logic signed [63:0] mul_res;
  logic signed [31:0] mul_a, mul_b;
  logic [2:0]         cnt6;

  logic [62:0]        num  [3];
  logic               neg  [3];
  logic [DW-1:0]      dvd  [3];
  logic [63:0]        rem  [3];
  logic [32:0]        quo  [3];
  logic               ovf  [3];
  logic [DCW-1:0]     div_cnt;

  logic signed [31:0] term [3];
  logic [2:0]         row;
  logic [2:0]         cons_j;

  // shared multiplier operands: squares first, then strength products
  always_comb begin
    unique case (mul_step)
      3'd0: begin mul_a = vo[0]; mul_b = vo[0]; end
      3'd1: begin mul_a = vo[1]; mul_b = vo[1]; end
      3'd2: begin mul_a = vo[2]; mul_b = vo[2]; end
      3'd3: begin mul_a = kk[0]; mul_b = vo[0]; end
      3'd4: begin mul_a = kk[1]; mul_b = vo[1]; end
      3'd5: begin mul_a = kk[2]; mul_b = vo[2]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_res = mul_a * mul_b;
  assign cons_j  = mul_step - 3'd1;
  assign row     = mfs_pkg::perm_row(permute_mode, cnt6);

  always_comb begin
    logic [32:0] lim;
    logic [32:0] mag;
    for (int c = 0; c < 3; c++) begin
      lim = neg[c] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      mag = (ovf[c] || quo[c] > lim) ? lim : quo[c];
      term[c] = neg[c] ? 32'(33'd0 - mag) : mag[31:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mfs_pkg::ST_IDLE:
        if (in_acc && is_query) begin
          state_next = (start_cnt == '0) ? mfs_pkg::ST_DONE : mfs_pkg::ST_READ;
        end
      mfs_pkg::ST_READ:  state_next = mfs_pkg::ST_LOAD;
      mfs_pkg::ST_LOAD:  state_next = mfs_pkg::ST_MUL;
      mfs_pkg::ST_MUL:
        if (mul_step == 3'd6) state_next = mfs_pkg::ST_CHECK;
      mfs_pkg::ST_CHECK:
        state_next = (dsq > {48'd0, min_distance_sq}) ? mfs_pkg::ST_DIV
                                                      : mfs_pkg::ST_NEXT;
      mfs_pkg::ST_DIV:
        if (div_cnt == DCW'(DW - 1)) state_next = mfs_pkg::ST_ACC;
      mfs_pkg::ST_ACC:   state_next = mfs_pkg::ST_NEXT;
      mfs_pkg::ST_NEXT:
        state_next = (pole_idx + CW'(1) == pole_cnt) ? mfs_pkg::ST_DONE
                                                     : mfs_pkg::ST_READ;
      mfs_pkg::ST_DONE:
        if (!out_valid || out_ready) state_next = mfs_pkg::ST_IDLE;
      default: state_next = mfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mfs_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic [64:0] trial;
    if (state == mfs_pkg::ST_DONE && (!out_valid || out_ready)) begin
      field_x <= acc[0];
      field_y <= acc[1];
      field_z <= acc[2];
    end
    unique case (state)
      mfs_pkg::ST_IDLE: begin
        qv[0]    <= pos_x;
        qv[1]    <= pos_y;
        qv[2]    <= pos_z;
        pole_cnt <= start_cnt;
        pole_idx <= '0;
        cnt6     <= 3'd0;
        for (int c = 0; c < 3; c++) acc[c] <= '0;
      end
      mfs_pkg::ST_LOAD: begin
        vo[0]    <= mfs_pkg::sat_sub(rd_data.pos_x, qv[0]);
        vo[1]    <= mfs_pkg::sat_sub(rd_data.pos_y, qv[1]);
        vo[2]    <= mfs_pkg::sat_sub(rd_data.pos_z, qv[2]);
        kk[0]    <= rd_data.str_x;
        kk[1]    <= rd_data.str_y;
        kk[2]    <= rd_data.str_z;
        dsq      <= '0;
        mul_step <= 3'd0;
      end
      mfs_pkg::ST_MUL: begin
        prod     <= mul_res;
        mul_step <= mul_step + 3'd1;
        // consume the product issued last cycle
        if (mul_step != 3'd0) begin
          if (cons_j < 3'd3) begin
            dsq <= dsq + 64'(prod);
          end else begin
            neg[2'(cons_j - 3'd3)] <= prod[63];
            num[2'(cons_j - 3'd3)] <= 63'(prod[63] ? -prod : prod);
          end
        end
      end
      mfs_pkg::ST_CHECK: begin
        div_cnt <= '0;
        for (int c = 0; c < 3; c++) begin
          dvd[c] <= {num[c], {FRAC_BITS{1'b0}}};
          rem[c] <= '0;
          quo[c] <= '0;
          ovf[c] <= 1'b0;
        end
      end
      mfs_pkg::ST_DIV: begin
        div_cnt <= div_cnt + DCW'(1);
        for (int c = 0; c < 3; c++) begin
          trial  = {rem[c], dvd[c][DW-1]};
          dvd[c] <= dvd[c] << 1;
          ovf[c] <= ovf[c] | quo[c][32];
          if (trial >= {1'b0, dsq}) begin
            rem[c] <= 64'(trial - {1'b0, dsq});
            quo[c] <= {quo[c][31:0], 1'b1};
          end else begin
            rem[c] <= trial[63:0];
            quo[c] <= {quo[c][31:0], 1'b0};
          end
        end
      end
      mfs_pkg::ST_ACC: begin
        for (int c = 0; c < 3; c++) begin
          acc[c] <= mfs_pkg::sat_add(acc[c], term[mfs_pkg::perm_src(row, 2'(c))]);
        end
        cnt6 <= (cnt6 == 3'd5) ? 3'd0 : cnt6 + 3'd1;
      end
      mfs_pkg::ST_NEXT: begin
        pole_idx <= pole_idx + CW'(1);
      end
      default: ;
    endcase
  end

  `MFS_ASSERT_NOW(a_read_in_range, state == mfs_pkg::ST_READ, pole_idx < pole_cnt)
  `MFS_ASSERT_NOW(a_div_nonzero, state == mfs_pkg::ST_DIV, dsq != 64'd0)
  `MFS_ASSERT_NEXT(a_done_shows, state == mfs_pkg::ST_DONE && (!out_valid || out_ready),
                   out_valid && state == mfs_pkg::ST_IDLE)
  `MFS_ASSERT_NOW(a_accept_idle, in_valid && in_ready, state == mfs_pkg::ST_IDLE)

endmodule
